// ===== sv/gcl_pkg.sv =====
// shared types, constants and helper functions for the grid cell locator
// no dependencies

package gcl_pkg;

    localparam int MAX_CELLS   = 1024;
    localparam int NODE_OFFSET = 0;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_DEPTH  = MAX_CELLS + 2 + NODE_OFFSET;
    localparam int TBL_DEPTH   = NUM_AXES * AXIS_DEPTH;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int CNT_W       = $clog2(MAX_CELLS + 1);
    localparam int NUM_STEPS   = $clog2(MAX_CELLS);
    localparam int COORD_W     = 32;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CELL_W      = 12;
    localparam int NIDX_W      = 11;

    localparam logic [1:0] AXIS_X      = 2'd0;
    localparam logic [1:0] AXIS_Y      = 2'd1;
    localparam logic [1:0] AXIS_Z      = 2'd2;
    localparam logic [1:0] AXIS_UNUSED = 2'd3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOCATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2
    } t_status;

    typedef logic [TBL_AW-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic                      req_type;
        logic [1:0]                axis;
        logic [NIDX_W-1:0]         node_index;
        logic signed [COORD_W-1:0] node_value;
        logic signed [COORD_W-1:0] query_coord;
    } t_in_beat;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_index;
        logic [1:0]               range_status;
        logic [1:0]               result_axis;
    } t_out_beat;

    // one item travelling down the pipe
    typedef struct packed {
        logic                      valid;
        logic                      query;
        logic                      wen;
        logic [1:0]                axis;
        t_addr                     waddr;
        logic signed [COORD_W-1:0] val;
        t_cnt                      n;
        t_cnt                      lo;
        t_cnt                      hi;
        t_cnt                      mid;
        logic                      act;
        t_status                   status;
    } t_item;

    function automatic t_addr axis_base(input logic [1:0] axis);
        t_addr b;
        case (axis)
            AXIS_X:  b = '0;
            AXIS_Y:  b = TBL_AW'(AXIS_DEPTH);
            AXIS_Z:  b = TBL_AW'(2 * AXIS_DEPTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic t_addr node_addr(input logic [1:0] axis, input t_cnt pos);
        return t_addr'(axis_base(axis) + TBL_AW'(pos) + TBL_AW'(NODE_OFFSET));
    endfunction

    // fold a pending table read into lo/hi
    function automatic t_item apply_step(input t_item it,
                                         input logic signed [COORD_W-1:0] node);
        t_item r;
        r = it;
        if (it.act) begin
            if (node <= it.val) begin
                r.lo = it.mid;
            end else begin
                r.hi = it.mid;
            end
        end
        r.act = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/gcl_ram.sv =====
// generic single-port table memory, registered read
// no dependencies

module gcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gcl_step.sv =====
// one bisection stage: folds in the previous read, issues the next midpoint read
// depends on gcl_pkg and gcl_ram

module gcl_step
    import gcl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_item                     i_item,
    input  logic signed [COORD_W-1:0] i_rdata,
    output t_item                     o_item,
    output logic signed [COORD_W-1:0] o_rdata
);

    t_item              r_item;
    t_item              n_item;
    logic [CNT_W:0]     sum;
    logic               ram_we;
    t_addr              ram_addr;
    logic [COORD_W-1:0] ram_rdata;

    always_comb begin
        n_item     = apply_step(i_item, i_rdata);
        sum        = {1'b0, n_item.lo} + {1'b0, n_item.hi};
        n_item.mid = t_cnt'(sum >> 1);
        n_item.act = i_item.valid && i_item.query && (i_item.status == ST_INSIDE)
                     && ((n_item.hi - n_item.lo) > t_cnt'(1));
    end

    assign ram_we   = i_en && i_item.valid && i_item.wen;
    assign ram_addr = i_item.wen ? i_item.waddr : node_addr(i_item.axis, n_item.mid);

    gcl_ram #(.WIDTH(COORD_W), .DEPTH(TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (i_en),
        .i_addr  (ram_addr),
        .i_wdata (i_item.val),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_rdata = $signed(ram_rdata);

endmodule

// ===== sv/grid_cell_locator_core.sv =====
// top level of the grid cell locator: bound check, bisection pipe, result register
// depends on gcl_pkg, gcl_ram and gcl_step

//  channel  | signals                        | beat
//  ---------+--------------------------------+---------------------------------
//  request  | i_valid, o_stall, i_data       | load node or locate coordinate
//  result   | o_valid, i_stall, o_data       | cell index, range status, axis
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data| cells per axis, no read-back
//
// one beat enters per cycle unless a held result stalls the pipe; a query passes its
// input register, the first/last node reads, each bisection level and result register
// each table read is registered, so every level owns a copy of the tables
// loads walk the same pipe and write each copy as they pass its stage
// reset (synchronous, active low) clears the valid bits and sets every cell count to 1
// a held result stalls the whole pipe; nothing is dropped or repeated

module grid_cell_locator_core
    import gcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_beat             i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_beat            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // cell count registers
    logic [CFG_W-1:0] r_cells [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_cells[a] <= CFG_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CELLS_X: r_cells[0] <= i_cfg_data;
                REG_CELLS_Y: r_cells[1] <= i_cfg_data;
                REG_CELLS_Z: r_cells[2] <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // whole pipe moves unless the result register is full and held
    logic en;
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // clamp the cell count of the requested axis
    logic [CFG_W-1:0] cfg_sel;
    t_cnt             n_used;

    always_comb begin
        case (i_data.axis)
            AXIS_X:  cfg_sel = r_cells[0];
            AXIS_Y:  cfg_sel = r_cells[1];
            AXIS_Z:  cfg_sel = r_cells[2];
            default: cfg_sel = CFG_W'(1);
        endcase
        if (cfg_sel == '0) begin
            n_used = t_cnt'(1);
        end else if (32'(cfg_sel) > MAX_CELLS) begin
            n_used = t_cnt'(MAX_CELLS);
        end else begin
            n_used = t_cnt'(cfg_sel);
        end
    end

    // stage 0: accepted beat in pipe form
    t_item r_s0;
    t_item n_s0;
    logic  axis_ok;

    always_comb begin
        axis_ok      = (i_data.axis != AXIS_UNUSED);
        n_s0         = '0;
        n_s0.valid   = i_valid && axis_ok;
        n_s0.query   = (i_data.req_type == REQ_LOCATE);
        n_s0.wen     = (i_data.req_type == REQ_LOAD)
                       && (32'(i_data.node_index) < AXIS_DEPTH);
        n_s0.axis    = i_data.axis;
        n_s0.waddr   = t_addr'(axis_base(i_data.axis) + TBL_AW'(i_data.node_index));
        n_s0.val     = (i_data.req_type == REQ_LOAD) ? i_data.node_value
                                                      : i_data.query_coord;
        n_s0.n       = n_used;
        n_s0.status  = ST_INSIDE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    // first and last node reads
    logic               bnd_we;
    logic [COORD_W-1:0] first_node;
    logic [COORD_W-1:0] last_node;
    t_addr              first_addr;
    t_addr              last_addr;

    assign bnd_we     = en && r_s0.valid && r_s0.wen;
    assign first_addr = r_s0.wen ? r_s0.waddr : node_addr(r_s0.axis, '0);
    assign last_addr  = r_s0.wen ? r_s0.waddr : node_addr(r_s0.axis, r_s0.n);

    gcl_ram #(.WIDTH(COORD_W), .DEPTH(TBL_DEPTH)) u_first (
        .i_clk   (i_clk),
        .i_we    (bnd_we),
        .i_re    (en),
        .i_addr  (first_addr),
        .i_wdata (r_s0.val),
        .o_rdata (first_node)
    );

    gcl_ram #(.WIDTH(COORD_W), .DEPTH(TBL_DEPTH)) u_last (
        .i_clk   (i_clk),
        .i_we    (bnd_we),
        .i_re    (en),
        .i_addr  (last_addr),
        .i_wdata (r_s0.val),
        .o_rdata (last_node)
    );

    t_item r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (en) begin
            r_s1 <= r_s0;
        end
    end

    // stage 1: range check, bisection starts on [0, n]
    t_item s1_chk;

    always_comb begin
        s1_chk     = r_s1;
        s1_chk.lo  = '0;
        s1_chk.hi  = r_s1.n;
        s1_chk.act = 1'b0;
        if (r_s1.val < $signed(first_node)) begin
            s1_chk.status = ST_BELOW;
        end else if ($signed(last_node) < r_s1.val) begin
            s1_chk.status = ST_ABOVE;
        end else begin
            s1_chk.status = ST_INSIDE;
        end
    end

    // bisection levels, one table copy each
    t_item                     st_item  [NUM_STEPS+1];
    logic signed [COORD_W-1:0] st_rdata [NUM_STEPS+1];

    assign st_item[0]  = s1_chk;
    assign st_rdata[0] = '0;

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        gcl_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (st_item[k]),
            .i_rdata (st_rdata[k]),
            .o_item  (st_item[k+1]),
            .o_rdata (st_rdata[k+1])
        );
    end

    // last fold and result formatting
    t_item     fin;
    t_out_beat n_out;
    t_out_beat r_out;

    always_comb begin
        fin                = apply_step(st_item[NUM_STEPS], st_rdata[NUM_STEPS]);
        n_out.result_axis  = fin.axis;
        n_out.range_status = fin.status;
        case (fin.status)
            ST_BELOW: n_out.cell_index = '1;
            ST_ABOVE: n_out.cell_index = $signed(CELL_W'(fin.n) + CELL_W'(1));
            default:  n_out.cell_index = $signed(CELL_W'(fin.lo));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin.valid && fin.query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    a_below_is_minus_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.range_status == ST_BELOW |-> o_data.cell_index == '1)
        else $error("below-grid result without cell index -1");

    a_no_axis3_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.result_axis != AXIS_UNUSED)
        else $error("result for unused axis");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1) && $stable(r_s0))
        else $error("pipe moved during stall");

    a_inside_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.range_status == ST_INSIDE |-> !o_data.cell_index[CELL_W-1])
        else $error("inside result with negative cell index");

endmodule

// ===== tb/grid_cell_locator_checker.sv =====
// checker for the grid cell locator: watches request, result and config ports,
// keeps its own node tables and cell counts and compares every result beat
// depends on gcl_pkg

module grid_cell_locator_checker
    import gcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_in_stall,
    input  t_in_beat             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_beat            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic signed [COORD_W-1:0] node_tbl [NUM_AXES][AXIS_DEPTH];
    logic [CFG_W-1:0]          cells_cfg [NUM_AXES];
    t_out_beat                 cell_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // clamped cell count, then bound check and plain bisection
    function automatic t_out_beat locate_cell(input logic [1:0] ax,
                                              input logic signed [COORD_W-1:0] c);
        t_out_beat r;
        int n;
        int lo;
        int hi;
        int mid;
        n = cells_cfg[ax];
        if (n < 1) n = 1;
        if (n > MAX_CELLS) n = MAX_CELLS;
        r.result_axis = ax;
        if (c < node_tbl[ax][NODE_OFFSET]) begin
            r.cell_index   = '1;
            r.range_status = ST_BELOW;
        end else if (node_tbl[ax][n + NODE_OFFSET] < c) begin
            r.cell_index   = CELL_W'(n + 1);
            r.range_status = ST_ABOVE;
        end else begin
            lo = 0;
            hi = n;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (node_tbl[ax][mid + NODE_OFFSET] <= c) lo = mid;
                else hi = mid;
            end
            r.cell_index   = CELL_W'(lo);
            r.range_status = ST_INSIDE;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                cells_cfg[a] = CFG_W'(1);
                for (int s = 0; s < AXIS_DEPTH; s++) node_tbl[a][s] = '0;
            end
            cell_queue.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < NUM_AXES) cells_cfg[i_cfg_idx] = i_cfg_data;
            if (i_valid && !i_in_stall && i_in_data.axis < NUM_AXES) begin
                if (i_in_data.req_type == REQ_LOAD) begin
                    if (i_in_data.node_index < AXIS_DEPTH)
                        node_tbl[i_in_data.axis][i_in_data.node_index] = i_in_data.node_value;
                end else begin
                    cell_queue.push_back(locate_cell(i_in_data.axis, i_in_data.query_coord));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (cell_queue.size() == 0) begin
                    report("unexpected result beat, cell", i_out_data.cell_index, 0);
                end else begin
                    want = cell_queue.pop_front();
                    if (i_out_data.cell_index !== want.cell_index)
                        report("cell_index", i_out_data.cell_index, want.cell_index);
                    if (i_out_data.range_status !== want.range_status)
                        report("range_status", i_out_data.range_status, want.range_status);
                    if (i_out_data.result_axis !== want.result_axis)
                        report("result_axis", i_out_data.result_axis, want.result_axis);
                end
            end
        end
        o_pending = cell_queue.size();
    end

endmodule

// ===== tb/grid_cell_locator_core_tb.sv =====
// testbench top for the grid cell locator: clock, reset, stimulus and verdict
// depends on gcl_pkg, grid_cell_locator_core and grid_cell_locator_checker

module grid_cell_locator_core_tb;
    import gcl_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in_beat             i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out_beat            o_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;
    int sender_idle = 0;   // percent of cycles the request side idles
    int recv_stall = 0;    // percent of cycles the result side stalls
    int node_vals [NUM_AXES][$];   // node values loaded this phase, per axis
    int cells_eff [NUM_AXES];

    grid_cell_locator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    grid_cell_locator_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall);
    end

    // generous cap on the whole run
    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

    // one request beat, held until accepted, then an optional idle gap
    task automatic send_beat(input t_in_beat b);
        i_data  <= b;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if ($urandom_range(99) < sender_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle);
        end
    endtask

    task automatic load_node(input logic [1:0] ax, input int idx, input int val);
        t_in_beat b;
        b.req_type    = REQ_LOAD;
        b.axis        = ax;
        b.node_index  = NIDX_W'(idx);
        b.node_value  = val;
        b.query_coord = $urandom;
        send_beat(b);
    endtask

    task automatic locate(input logic [1:0] ax, input int c);
        t_in_beat b;
        b.req_type    = REQ_LOCATE;
        b.axis        = ax;
        b.node_index  = NIDX_W'($urandom);
        b.node_value  = $urandom;
        b.query_coord = c;
        send_beat(b);
    endtask

    // wait out every result, then the pipe depth for trailing loads
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (NUM_STEPS + 20) @(posedge i_clk);
    endtask

    task automatic write_cells(input int nx, input int ny, input int nz);
        int v [NUM_AXES];
        v = '{nx, ny, nz};
        drain();
        for (int a = 0; a < NUM_AXES; a++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= (a == 0) ? REG_CELLS_X : (a == 1) ? REG_CELLS_Y : REG_CELLS_Z;
            i_cfg_data <= CFG_W'(v[a]);
            @(posedge i_clk);
            cells_eff[a] = (v[a] < 1) ? 1 : (v[a] > MAX_CELLS) ? MAX_CELLS : v[a];
        end
        i_cfg_we <= 1'b0;
    endtask

    // nodes 0..n of one axis: wide sorted, clustered sorted with repeats, or unsorted
    task automatic fill_axis(input logic [1:0] ax, input int n, input int shape);
        int base;
        node_vals[ax].delete();
        base = $urandom;
        for (int i = 0; i <= n; i++) begin
            if (shape == 1) node_vals[ax].push_back(base + $urandom_range(0, 2 * n));
            else node_vals[ax].push_back($urandom);
        end
        if (shape != 2) node_vals[ax].sort();
        for (int i = 0; i <= n; i++) load_node(ax, i, node_vals[ax][i]);
    endtask

    // coordinate near a node most of the time, else wide or extreme
    function automatic int pick_coord(input logic [1:0] ax);
        int k;
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: begin
                k = $urandom_range(0, node_vals[ax].size() - 1);
                return node_vals[ax][k] + $urandom_range(0, 2) - 1;
            end
        endcase
    endfunction

    // random queries over loaded axes, with some ignored beats mixed in
    task automatic run_queries(input int count);
        logic [1:0] ax;
        for (int q = 0; q < count; q++) begin
            ax = 2'($urandom_range(0, NUM_AXES - 1));
            if ($urandom_range(9) == 0) begin
                // noise: unused axis or out-of-table load
                if ($urandom_range(1)) locate(AXIS_UNUSED, $urandom);
                else load_node(ax, $urandom_range(AXIS_DEPTH, 2047), $urandom);
            end
            locate(ax, pick_coord(ax));
        end
    endtask

    initial begin
        int nx;
        int ny;
        int nz;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset counts of one cell, two nodes per axis
        cells_eff = '{1, 1, 1};
        for (int a = 0; a < NUM_AXES; a++) begin
            node_vals[a] = '{-100, 100};
            load_node(2'(a), 0, -100);
            load_node(2'(a), 1, 100);
        end
        locate(AXIS_X, -101);            // below first node
        locate(AXIS_X, -100);            // on first node
        locate(AXIS_Y, 0);
        locate(AXIS_Y, 100);             // on last node, last cell is closed
        locate(AXIS_Z, 101);             // above last node
        locate(AXIS_Z, 32'h8000_0000);
        locate(AXIS_X, 32'h7fff_ffff);
        locate(AXIS_UNUSED, 0);          // unused axis, ignored
        load_node(AXIS_UNUSED, 0, 12345);
        load_node(AXIS_X, 2047, 0);      // slots past the table are ignored
        load_node(AXIS_Y, AXIS_DEPTH, 0);
        load_node(AXIS_Z, AXIS_DEPTH - 1, 32'h7fff_ffff);
        locate(AXIS_X, 50);
        locate(AXIS_Y, 100);
        write_cells(0, 1, 0);            // zero counts behave as one
        locate(AXIS_X, 100);
        locate(AXIS_Z, -100);

        // random phases over settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            nx = $urandom_range(1, 8);
            ny = $urandom_range(1, 16);
            nz = $urandom_range(1, 8);
            if (ph == 5) nx = MAX_CELLS;  // full x table, loaded once
            sender_idle = 0;
            recv_stall  = 0;
            write_cells(nx, ny, nz);
            case (ph % 4)
                1: sender_idle = 71;
                2: recv_stall  = 71;
                3: begin
                    sender_idle = 33;
                    recv_stall  = 33;
                end
                default: ;
            endcase
            for (int a = 0; a < NUM_AXES; a++)
                fill_axis(2'(a), cells_eff[a], $urandom_range(0, 2));
            run_queries(12);
            if (ph == 5) begin
                // counts above the maximum clamp to it, zero acts as one
                write_cells(2047, ny, 0);
                run_queries(6);
                write_cells(MAX_CELLS + 1, 0, nz);
                run_queries(6);
            end
        end

        sender_idle = 0;
        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
